>>> hw/rtl/assert_macros.svh
// Concurrent assertion helpers, disabled while reset is asserted
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge
`define ASSERT_ALWAYS(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hw/rtl/lpr_pkg.sv
package lpr_pkg;

    localparam int COORD_BITS   = 10;
    localparam int COLOR_BITS   = 16;
    localparam int ERR_BITS     = COORD_BITS + 2;

    localparam int IN_FIELD_BITS  = 4 * COORD_BITS + COLOR_BITS;
    localparam int IN_DATA_BITS   = ((IN_FIELD_BITS + 7) / 8) * 8;
    localparam int OUT_FIELD_BITS = 2 * COORD_BITS + COLOR_BITS;
    localparam int OUT_DATA_BITS  = ((OUT_FIELD_BITS + 7) / 8) * 8;

    localparam int Q_DEPTH     = 4;
    localparam int Q_PTR_BITS  = $clog2(Q_DEPTH);
    localparam int Q_CNT_BITS  = $clog2(Q_DEPTH + 1);

    typedef logic [COORD_BITS-1:0]        t_coord;
    typedef logic [COLOR_BITS-1:0]        t_color;
    typedef logic signed [ERR_BITS-1:0]   t_err;

    typedef enum logic {
        OP_LOAD    = 1'b0,
        OP_ADVANCE = 1'b1
    } t_opcode;

    // Classified command, with the line set-up already worked out for a load
    typedef struct packed {
        t_opcode op;
        t_coord  start_x;
        t_coord  start_y;
        t_coord  goal_x;
        t_coord  goal_y;
        t_coord  delta_x;
        t_coord  delta_y;
        logic    dir_x_neg;
        logic    dir_y_neg;
        t_err    error_init;
        t_color  color;
    } t_cmd;

endpackage

>>> hw/rtl/lpr_front.sv
module lpr_front (
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // start_x, start_y, finish_x, finish_y, line_color (lowest bit up)
    input  logic [lpr_pkg::IN_DATA_BITS-1:0] s_axis_tdata,
    // opcode
    input  logic                             s_axis_tuser,
    input  logic                             i_q_full,
    output logic                             o_push,
    output lpr_pkg::t_cmd                    o_cmd
);
    import lpr_pkg::*;

    t_coord x0, y0, x1, y1, dx, dy;

    assign x0 = s_axis_tdata[COORD_BITS-1:0];
    assign y0 = s_axis_tdata[2*COORD_BITS-1:COORD_BITS];
    assign x1 = s_axis_tdata[3*COORD_BITS-1:2*COORD_BITS];
    assign y1 = s_axis_tdata[4*COORD_BITS-1:3*COORD_BITS];

    assign dx = (x1 >= x0) ? t_coord'(x1 - x0) : t_coord'(x0 - x1);
    assign dy = (y1 >= y0) ? t_coord'(y1 - y0) : t_coord'(y0 - y1);

    assign s_axis_tready = !i_q_full;
    assign o_push        = s_axis_tvalid && !i_q_full;

    always_comb begin
        o_cmd.op         = t_opcode'(s_axis_tuser);
        o_cmd.start_x    = x0;
        o_cmd.start_y    = y0;
        o_cmd.goal_x     = x1;
        o_cmd.goal_y     = y1;
        o_cmd.delta_x    = dx;
        o_cmd.delta_y    = dy;
        o_cmd.dir_x_neg  = !(x0 < x1);
        o_cmd.dir_y_neg  = !(y0 < y1);
        o_cmd.color      = s_axis_tdata[4*COORD_BITS+COLOR_BITS-1:4*COORD_BITS];
        // x-major lines start at half of dx, others at minus half of dy
        if (dx > dy) begin
            o_cmd.error_init = t_err'({2'b00, dx >> 1});
        end else begin
            o_cmd.error_init = -t_err'({2'b00, dy >> 1});
        end
    end

endmodule

>>> hw/rtl/lpr_queue.sv
module lpr_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  lpr_pkg::t_cmd i_cmd,
    input  logic          i_pop,
    output logic          o_full,
    output logic          o_valid,
    output lpr_pkg::t_cmd o_cmd
);
    import lpr_pkg::*;

    t_cmd                  r_mem [Q_DEPTH];
    logic [Q_PTR_BITS-1:0] r_wr_ptr, n_wr_ptr;
    logic [Q_PTR_BITS-1:0] r_rd_ptr, n_rd_ptr;
    logic [Q_CNT_BITS-1:0] r_count, n_count;

    assign o_full  = (r_count == Q_CNT_BITS'(Q_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = i_push ? Q_PTR_BITS'(r_wr_ptr + 1'b1) : r_wr_ptr;
        n_rd_ptr = i_pop  ? Q_PTR_BITS'(r_rd_ptr + 1'b1) : r_rd_ptr;
        n_count  = r_count;
        if (i_push && !i_pop) begin
            n_count = Q_CNT_BITS'(r_count + 1'b1);
        end else if (!i_push && i_pop) begin
            n_count = Q_CNT_BITS'(r_count - 1'b1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

`include "assert_macros.svh"
    `ASSERT_ALWAYS(a_no_overflow, i_clk, i_rst_n, !(i_push && o_full && !i_pop),
        "queue written while full")
    `ASSERT_ALWAYS(a_no_underflow, i_clk, i_rst_n, !(i_pop && r_count == '0),
        "queue read while empty")
    `ASSERT_NEXT(a_count_tracks, i_clk, i_rst_n, i_push && !i_pop && !o_full,
        r_count == Q_CNT_BITS'($past(r_count) + 1'b1), "fill count lost an item")

endmodule

>>> hw/rtl/lpr_back.sv
module lpr_back (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_q_valid,
    input  lpr_pkg::t_cmd                     i_cmd,
    output logic                              o_pop,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // pixel_x, pixel_y, pixel_color, zero fill (lowest bit up)
    output logic [lpr_pkg::OUT_DATA_BITS-1:0] m_axis_tdata,
    output logic                              m_axis_tlast
);
    import lpr_pkg::*;

    t_coord r_cur_x, r_cur_y, r_goal_x, r_goal_y, r_delta_x, r_delta_y;
    logic   r_dir_x_neg, r_dir_y_neg, r_busy;
    t_err   r_err;
    t_color r_color;

    logic   r_out_valid, r_out_last;
    t_coord r_out_x, r_out_y;
    t_color r_out_color;

    logic   out_free, is_load, emit, at_goal, step_x, step_y;
    t_err   dx_s, dy_s, n_err;
    t_coord n_cur_x, n_cur_y;

    assign out_free = !r_out_valid || m_axis_tready;
    assign is_load  = i_q_valid && (i_cmd.op == OP_LOAD);
    assign emit     = i_q_valid && (i_cmd.op == OP_ADVANCE) && r_busy && out_free;
    // drop advances while idle; hold an advance only while the output is stalled
    assign o_pop    = is_load || emit || (i_q_valid && (i_cmd.op == OP_ADVANCE) && !r_busy);

    assign at_goal = (r_cur_x == r_goal_x) && (r_cur_y == r_goal_y);
    assign dx_s    = t_err'({2'b00, r_delta_x});
    assign dy_s    = t_err'({2'b00, r_delta_y});
    assign step_x  = r_err > -dx_s;
    assign step_y  = r_err < dy_s;

    always_comb begin
        n_err   = r_err - (step_x ? dy_s : t_err'(0)) + (step_y ? dx_s : t_err'(0));
        n_cur_x = r_cur_x;
        n_cur_y = r_cur_y;
        if (step_x) begin
            n_cur_x = r_dir_x_neg ? t_coord'(r_cur_x - 1'b1) : t_coord'(r_cur_x + 1'b1);
        end
        if (step_y) begin
            n_cur_y = r_dir_y_neg ? t_coord'(r_cur_y - 1'b1) : t_coord'(r_cur_y + 1'b1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
            r_cur_x     <= '0;
            r_cur_y     <= '0;
            r_goal_x    <= '0;
            r_goal_y    <= '0;
            r_delta_x   <= '0;
            r_delta_y   <= '0;
            r_dir_x_neg <= 1'b0;
            r_dir_y_neg <= 1'b0;
            r_err       <= '0;
            r_color     <= '0;
        end else begin
            if (is_load) begin
                r_busy      <= 1'b1;
                r_cur_x     <= i_cmd.start_x;
                r_cur_y     <= i_cmd.start_y;
                r_goal_x    <= i_cmd.goal_x;
                r_goal_y    <= i_cmd.goal_y;
                r_delta_x   <= i_cmd.delta_x;
                r_delta_y   <= i_cmd.delta_y;
                r_dir_x_neg <= i_cmd.dir_x_neg;
                r_dir_y_neg <= i_cmd.dir_y_neg;
                r_err       <= i_cmd.error_init;
                r_color     <= i_cmd.color;
            end else if (emit) begin
                if (at_goal) begin
                    r_busy <= 1'b0;
                end else begin
                    r_err   <= n_err;
                    r_cur_x <= n_cur_x;
                    r_cur_y <= n_cur_y;
                end
            end
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out_x     <= r_cur_x;
            r_out_y     <= r_cur_y;
            r_out_color <= r_color;
            r_out_last  <= at_goal;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tlast  = r_out_last;
    assign m_axis_tdata  = OUT_DATA_BITS'({r_out_color, r_out_y, r_out_x});

`include "assert_macros.svh"
    `ASSERT_NEXT(a_idle_after_last, i_clk, i_rst_n, emit && at_goal, !r_busy,
        "still busy after the end point")
    `ASSERT_ALWAYS(a_no_overwrite, i_clk, i_rst_n, !(emit && r_out_valid && !m_axis_tready),
        "pixel emitted over a stalled one")
    `ASSERT_NEXT(a_emit_shows, i_clk, i_rst_n, emit, m_axis_tvalid,
        "emitted pixel not presented")

endmodule

>>> hw/rtl/line_pixel_rasterizer_top.sv
// An advance item passes through the command queue; the back end registers its pixel as it pops the item.
// Throughput: one item per cycle while the output is not stalled; error and coordinates update with each pixel.
// A four-entry command queue lets input and output stall independently.
// Loads and advances while idle give no pixel but are still popped by the back end.
// Reset is synchronous, active low: clears the queue, the line state and the output.
module line_pixel_rasterizer_top (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // start_x, start_y, finish_x, finish_y, line_color (lowest bit up)
    input  logic [lpr_pkg::IN_DATA_BITS-1:0]  s_axis_tdata,
    // opcode
    input  logic                              s_axis_tuser,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // pixel_x, pixel_y, pixel_color, zero fill (lowest bit up)
    output logic [lpr_pkg::OUT_DATA_BITS-1:0] m_axis_tdata,
    output logic                              m_axis_tlast
);
    import lpr_pkg::*;

    logic push, pop, q_full, q_valid;
    t_cmd push_cmd, head_cmd;

    lpr_front u_front (
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .i_q_full      (q_full),
        .o_push        (push),
        .o_cmd         (push_cmd)
    );

    lpr_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_cmd   (head_cmd)
    );

    lpr_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_valid     (q_valid),
        .i_cmd         (head_cmd),
        .o_pop         (pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule
